/* rtl/pidc_pkg.sv */
// Shared types and constants of the incremental/positional PID controller.
package pidc_pkg;

    // Fixed register widths
    localparam int GAIN_W     = 16;
    localparam int CLAMP_W    = 16;
    localparam int LIMIT_W    = 15;
    localparam int SUM_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_PID_FORM    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_MAX   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_MIN   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_LIMIT = 3'd6;

    // Controller forms
    localparam logic FORM_INCREMENTAL = 1'b0;
    localparam logic FORM_POSITIONAL  = 1'b1;

    // Input actions
    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Reset values of the registers
    localparam logic [CLAMP_W-1:0] DRIVE_MAX_RST   = 16'h7FFF;
    localparam logic [CLAMP_W-1:0] DRIVE_MIN_RST   = 16'h8000;
    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 15'd19660;

    // Configuration register set
    typedef struct packed {
        logic                       pid_form;
        logic [GAIN_W-1:0]          prop_gain;
        logic [GAIN_W-1:0]          integ_gain;
        logic [GAIN_W-1:0]          deriv_gain;
        logic signed [CLAMP_W-1:0]  drive_max;
        logic signed [CLAMP_W-1:0]  drive_min;
        logic [LIMIT_W-1:0]         integ_limit;
    } cfg_t;

endpackage

/* rtl/pidc_step.sv */
// One controller step: error, gain products, accumulation, clamps and next state.
module pidc_step #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  pidc_pkg::cfg_t                                    cfg,
    input  logic                                              action,
    input  logic signed [DATA_WIDTH-1:0]                      setpoint,
    input  logic signed [DATA_WIDTH-1:0]                      measured,
    input  logic signed [DATA_WIDTH:0]                        last_error,
    input  logic signed [DATA_WIDTH:0]                        prior_error,
    input  logic signed [pidc_pkg::SUM_W-1:0]                 error_sum,
    input  logic signed [pidc_pkg::CLAMP_W+FRAC_BITS-1:0]     drive_acc,
    output logic signed [DATA_WIDTH:0]                        last_error_next,
    output logic signed [DATA_WIDTH:0]                        prior_error_next,
    output logic signed [pidc_pkg::SUM_W-1:0]                 error_sum_next,
    output logic signed [pidc_pkg::CLAMP_W+FRAC_BITS-1:0]     drive_acc_next,
    output logic signed [DATA_WIDTH-1:0]                      drive_next
);

    localparam int EW  = DATA_WIDTH + 1;
    localparam int TW  = DATA_WIDTH + 3;
    localparam int OW  = (TW > pidc_pkg::SUM_W) ? TW : pidc_pkg::SUM_W;
    localparam int PW  = OW + pidc_pkg::GAIN_W + 1;
    localparam int AW  = pidc_pkg::CLAMP_W + FRAC_BITS;
    localparam int SW0 = (PW > AW) ? PW : AW;
    localparam int SW  = SW0 + 2;

    logic signed [EW-1:0] err;
    logic signed [TW-1:0] diff1;
    logic signed [TW-1:0] diff2;
    logic signed [SW-1:0] sum_raw;
    logic signed [SW-1:0] sum_lim;
    logic signed [SW-1:0] sum_clamp;
    logic signed [pidc_pkg::SUM_W-1:0] sum_new;
    logic signed [OW-1:0] op_p;
    logic signed [OW-1:0] op_i;
    logic signed [OW-1:0] op_d;
    logic signed [PW-1:0] prod_p;
    logic signed [PW-1:0] prod_i;
    logic signed [PW-1:0] prod_d;
    logic signed [SW-1:0] acc_base;
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] acc_hi;
    logic signed [SW-1:0] acc_lo;
    logic signed [SW-1:0] acc_clamp;
    logic signed [SW-1:0] acc_int;
    logic                 positional;

    assign positional = (cfg.pid_form == pidc_pkg::FORM_POSITIONAL);

    // Error and its differences
    assign err   = EW'(setpoint) - EW'(measured);
    assign diff1 = TW'(err) - TW'(last_error);
    assign diff2 = TW'(err) - (TW'(last_error) <<< 1) + TW'(prior_error);

    // Error sum with symmetric clamp (positional form)
    assign sum_raw = SW'(error_sum) + SW'(err);
    assign sum_lim = SW'($signed({1'b0, cfg.integ_limit}));
    always_comb
    begin
        sum_clamp = sum_raw;
        if (sum_clamp > sum_lim)
            sum_clamp = sum_lim;
        if (sum_clamp < -sum_lim)
            sum_clamp = -sum_lim;
    end
    assign sum_new = sum_clamp[pidc_pkg::SUM_W-1:0];

    // Multiplier operands, shared between the two forms
    assign op_p = positional ? OW'(err)     : OW'(diff1);
    assign op_i = positional ? OW'(sum_new) : OW'(err);
    assign op_d = positional ? OW'(diff1)   : OW'(diff2);

    // Gain products, exact in Q.FRAC_BITS
    assign prod_p = PW'(op_p) * PW'($signed({1'b0, cfg.prop_gain}));
    assign prod_i = PW'(op_i) * PW'($signed({1'b0, cfg.integ_gain}));
    assign prod_d = PW'(op_d) * PW'($signed({1'b0, cfg.deriv_gain}));

    // Accumulate; incremental form builds on the stored accumulator
    assign acc_base = positional ? '0 : SW'(drive_acc);
    assign acc      = acc_base + SW'(prod_p) + SW'(prod_i) + SW'(prod_d);

    // Drive clamp, upper bound tested first
    assign acc_hi = SW'($signed(cfg.drive_max)) <<< FRAC_BITS;
    assign acc_lo = SW'($signed(cfg.drive_min)) <<< FRAC_BITS;
    always_comb
    begin
        if (acc > acc_hi)
            acc_clamp = acc_hi;
        else if (acc < acc_lo)
            acc_clamp = acc_lo;
        else
            acc_clamp = acc;
    end
    assign acc_int = acc_clamp >>> FRAC_BITS;

    // Next state and drive; clear zeroes everything
    always_comb
    begin
        if (action == pidc_pkg::ACT_CLEAR)
        begin
            last_error_next  = '0;
            prior_error_next = '0;
            error_sum_next   = '0;
            drive_acc_next   = '0;
            drive_next       = '0;
        end
        else
        begin
            last_error_next  = err;
            prior_error_next = positional ? prior_error : last_error;
            error_sum_next   = positional ? sum_new : error_sum;
            drive_acc_next   = acc_clamp[AW-1:0];
            drive_next       = acc_int[DATA_WIDTH-1:0];
        end
    end

endmodule

/* rtl/pid_controller_incremental_positional_core.sv */
// Top level of the incremental/positional PID controller core.
//
// Input channel (in_valid/in_ready) carries one transaction per control step:
// action selects a step or a clear, setpoint and measured are signed integers.
// Output channel (out_valid/out_ready) returns one drive value per input
// transaction, in order; a clear returns 0.
// Registers are written through cfg_wr_en/cfg_addr/cfg_wdata while the core
// is idle, which binds the user; the core does not enforce it. Writes to
// unused indexes are dropped. Path: an accepted transaction is captured in
// the input register, then in the output register (out_valid) when that is free.
// Throughput: one transaction per cycle while out_ready holds. The step (three
// gain multiplies, sum and clamps) runs combinationally between the input and
// output registers, because the error history and accumulator feed back.
// Stall: the output register holds the result; the input register can still
// take one more transaction, after which in_ready drops until out_ready.
// Reset: clears the pipeline, the error history, the error sum and the
// accumulator, and loads the register defaults.
module pid_controller_incremental_positional_core #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pidc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [DATA_WIDTH-1:0]        setpoint,
    input  logic signed [DATA_WIDTH-1:0]        measured,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [DATA_WIDTH-1:0]        drive
);

    localparam int AW = pidc_pkg::CLAMP_W + FRAC_BITS;

    pidc_pkg::cfg_t cfg_reg;

    logic                             s1_valid_reg;
    logic                             s1_action_reg;
    logic signed [DATA_WIDTH-1:0]     s1_setpoint_reg;
    logic signed [DATA_WIDTH-1:0]     s1_measured_reg;

    logic signed [DATA_WIDTH:0]       last_error_reg;
    logic signed [DATA_WIDTH:0]       prior_error_reg;
    logic signed [pidc_pkg::SUM_W-1:0] error_sum_reg;
    logic signed [AW-1:0]             drive_acc_reg;

    logic signed [DATA_WIDTH:0]       last_error_next;
    logic signed [DATA_WIDTH:0]       prior_error_next;
    logic signed [pidc_pkg::SUM_W-1:0] error_sum_next;
    logic signed [AW-1:0]             drive_acc_next;
    logic signed [DATA_WIDTH-1:0]     drive_next;

    logic                             out_valid_reg;
    logic signed [DATA_WIDTH-1:0]     drive_reg;

    logic                             s1_adv;
    logic                             in_acc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pid_form    <= pidc_pkg::FORM_INCREMENTAL;
            cfg_reg.prop_gain   <= '0;
            cfg_reg.integ_gain  <= '0;
            cfg_reg.deriv_gain  <= '0;
            cfg_reg.drive_max   <= pidc_pkg::DRIVE_MAX_RST;
            cfg_reg.drive_min   <= pidc_pkg::DRIVE_MIN_RST;
            cfg_reg.integ_limit <= pidc_pkg::INTEG_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                pidc_pkg::REG_PID_FORM:    cfg_reg.pid_form    <= cfg_wdata[0];
                pidc_pkg::REG_PROP_GAIN:   cfg_reg.prop_gain   <= cfg_wdata;
                pidc_pkg::REG_INTEG_GAIN:  cfg_reg.integ_gain  <= cfg_wdata;
                pidc_pkg::REG_DERIV_GAIN:  cfg_reg.deriv_gain  <= cfg_wdata;
                pidc_pkg::REG_DRIVE_MAX:   cfg_reg.drive_max   <= cfg_wdata;
                pidc_pkg::REG_DRIVE_MIN:   cfg_reg.drive_min   <= cfg_wdata;
                pidc_pkg::REG_INTEG_LIMIT:
                    cfg_reg.integ_limit <= cfg_wdata[pidc_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: stage 1 moves on when the output register is free or drained
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_acc   = in_valid && in_ready;

    // Input register, control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // Input register, payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_action_reg   <= action;
            s1_setpoint_reg <= setpoint;
            s1_measured_reg <= measured;
        end
    end

    // Step datapath
    pidc_step #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_step (
        .cfg              (cfg_reg),
        .action           (s1_action_reg),
        .setpoint         (s1_setpoint_reg),
        .measured         (s1_measured_reg),
        .last_error       (last_error_reg),
        .prior_error      (prior_error_reg),
        .error_sum        (error_sum_reg),
        .drive_acc        (drive_acc_reg),
        .last_error_next  (last_error_next),
        .prior_error_next (prior_error_next),
        .error_sum_next   (error_sum_next),
        .drive_acc_next   (drive_acc_next),
        .drive_next       (drive_next)
    );

    // Controller state, updated as each transaction leaves stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg  <= '0;
            prior_error_reg <= '0;
            error_sum_reg   <= '0;
            drive_acc_reg   <= '0;
        end
        else if (s1_adv)
        begin
            last_error_reg  <= last_error_next;
            prior_error_reg <= prior_error_next;
            error_sum_reg   <= error_sum_next;
            drive_acc_reg   <= drive_acc_next;
        end
    end

    // Output register, control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ready)
            out_valid_reg <= s1_valid_reg;
    end

    // Output register, payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            drive_reg <= drive_next;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

/* rtl/pidc_checker.sv */
// Port-level checks of the PID controller core, bound to the top level.
module pidc_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             action,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [DATA_WIDTH-1:0]     drive
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive))
        else $error("stalled output changed");

    // Input backpressure only comes from a stalled, full output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    // A clear transaction returns zero, through the input and output registers, when the sink is ready
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == pidc_pkg::ACT_CLEAR) ##1 out_ready
        |=> out_valid && drive == '0)
        else $error("clear did not return zero drive");

    // A new result appears only after an accepted transaction has passed the input and output registers
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("output appeared without input transaction");

endmodule

bind pid_controller_incremental_positional_core pidc_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_pidc_checker (.*);

/* tb/pidc_drive_checker.sv */
// Checker for the PID core: tracks the registers, predicts each drive value and compares.
module pidc_drive_checker #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pidc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pidc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                action,
    input  logic signed [DATA_WIDTH-1:0]        setpoint,
    input  logic signed [DATA_WIDTH-1:0]        measured,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [DATA_WIDTH-1:0]        drive,
    output int                                  outstanding,
    output int                                  errors
);

    localparam longint ONE_Q = longint'(1) << FRAC_BITS;

    // Shadow registers and controller state
    pidc_pkg::cfg_t                         regs;
    logic signed [DATA_WIDTH:0]             err_prev;
    logic signed [DATA_WIDTH:0]             err_prior;
    logic signed [pidc_pkg::SUM_W-1:0]      err_sum;
    logic signed [DATA_WIDTH+FRAC_BITS-1:0] acc_q;

    // Drive values still owed by the core, oldest first
    logic signed [DATA_WIDTH-1:0] drive_due[$];
    logic signed [DATA_WIDTH-1:0] drive_want;
    int issued;
    int retired;

    assign outstanding = issued - retired;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    // One control step; updates the shadow state and returns the drive value
    function automatic logic signed [DATA_WIDTH-1:0] next_drive(
        input logic                         act,
        input logic signed [DATA_WIDTH-1:0] sp,
        input logic signed [DATA_WIDTH-1:0] ms
    );
        longint e, el, ep, kp, ki, kd, s, lim, acc, hi, lo;
        if (act == pidc_pkg::ACT_CLEAR)
        begin
            err_prev  = '0;
            err_prior = '0;
            err_sum   = '0;
            acc_q     = '0;
            return '0;
        end
        e  = longint'(sp) - longint'(ms);
        el = longint'(err_prev);
        ep = longint'(err_prior);
        kp = longint'(regs.prop_gain);
        ki = longint'(regs.integ_gain);
        kd = longint'(regs.deriv_gain);
        if (regs.pid_form == pidc_pkg::FORM_INCREMENTAL)
        begin
            acc = longint'(acc_q) + kp * (e - el) + ki * e + kd * (e - 2 * el + ep);
        end
        else
        begin
            // error sum saturates symmetrically
            lim = longint'(regs.integ_limit);
            s = longint'(err_sum) + e;
            if (s > lim)
                s = lim;
            if (s < -lim)
                s = -lim;
            err_sum = s[pidc_pkg::SUM_W-1:0];
            acc = kp * e + ki * s + kd * (e - el);
        end
        // upper bound wins when the bounds are crossed
        hi = longint'($signed(regs.drive_max)) * ONE_Q;
        lo = longint'($signed(regs.drive_min)) * ONE_Q;
        if (acc > hi)
            acc = hi;
        else if (acc < lo)
            acc = lo;
        acc_q = acc[DATA_WIDTH+FRAC_BITS-1:0];
        // positional form keeps the older error untouched
        if (regs.pid_form == pidc_pkg::FORM_INCREMENTAL)
            err_prior = err_prev;
        err_prev = e[DATA_WIDTH:0];
        acc = acc >>> FRAC_BITS;
        return acc[DATA_WIDTH-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            regs.pid_form    = pidc_pkg::FORM_INCREMENTAL;
            regs.prop_gain   = '0;
            regs.integ_gain  = '0;
            regs.deriv_gain  = '0;
            regs.drive_max   = pidc_pkg::DRIVE_MAX_RST;
            regs.drive_min   = pidc_pkg::DRIVE_MIN_RST;
            regs.integ_limit = pidc_pkg::INTEG_LIMIT_RST;
            err_prev  = '0;
            err_prior = '0;
            err_sum   = '0;
            acc_q     = '0;
            drive_due.delete();
            issued  <= 0;
            retired <= 0;
        end
        else
        begin
            // register writes; unused indexes fall through
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    pidc_pkg::REG_PID_FORM:
                        regs.pid_form    = cfg_wdata[0];
                    pidc_pkg::REG_PROP_GAIN:
                        regs.prop_gain   = cfg_wdata[pidc_pkg::GAIN_W-1:0];
                    pidc_pkg::REG_INTEG_GAIN:
                        regs.integ_gain  = cfg_wdata[pidc_pkg::GAIN_W-1:0];
                    pidc_pkg::REG_DERIV_GAIN:
                        regs.deriv_gain  = cfg_wdata[pidc_pkg::GAIN_W-1:0];
                    pidc_pkg::REG_DRIVE_MAX:
                        regs.drive_max   = cfg_wdata[pidc_pkg::CLAMP_W-1:0];
                    pidc_pkg::REG_DRIVE_MIN:
                        regs.drive_min   = cfg_wdata[pidc_pkg::CLAMP_W-1:0];
                    pidc_pkg::REG_INTEG_LIMIT:
                        regs.integ_limit = cfg_wdata[pidc_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end

            // result transaction against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (drive_due.size() == 0)
                begin
                    report_mismatch($sformatf("drive %0d with nothing pending", drive));
                end
                else
                begin
                    drive_want = drive_due.pop_front();
                    if (drive !== drive_want)
                        report_mismatch($sformatf("drive %0d, expected %0d (result %0d)",
                                                  drive, drive_want, retired));
                    retired <= retired + 1;
                end
            end

            // input transaction
            if (in_valid && in_ready)
            begin
                drive_due.push_back(next_drive(action, setpoint, measured));
                issued <= issued + 1;
            end
        end
    end

endmodule

/* tb/tb.sv */
// Testbench top for the PID core: stimulus, flow control, watchdog and verdict.
module tb;

    localparam int DW             = 16;
    localparam int FRAC           = 8;
    localparam logic [pidc_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ITEMS    = 100;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_wr_en;
    logic [pidc_pkg::CFG_ADDR_W-1:0]      cfg_addr;
    logic [pidc_pkg::CFG_DATA_W-1:0]      cfg_wdata;
    logic                                 in_valid;
    logic                                 in_ready;
    logic                                 action;
    logic signed [DW-1:0]                 setpoint;
    logic signed [DW-1:0]                 measured;
    logic                                 out_valid;
    logic                                 out_ready;
    logic signed [DW-1:0]                 drive;

    int   outstanding;
    int   errors;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;
    logic hold_req;
    logic hold_taken;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    pid_controller_incremental_positional_core #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .setpoint   (setpoint),
        .measured   (measured),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive      (drive)
    );

    pidc_drive_checker #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC)
    ) drive_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .setpoint    (setpoint),
        .measured    (measured),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive       (drive),
        .outstanding (outstanding),
        .errors      (errors)
    );

    // Watchdog: ends the run after too long without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [pidc_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [pidc_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Full register set; spare data bits carry noise, plus a write to an unused index
    task automatic load_regs(input pidc_pkg::cfg_t r);
        write_reg(pidc_pkg::REG_PID_FORM,    {15'($urandom), r.pid_form});
        write_reg(pidc_pkg::REG_PROP_GAIN,   r.prop_gain);
        write_reg(pidc_pkg::REG_INTEG_GAIN,  r.integ_gain);
        write_reg(pidc_pkg::REG_DERIV_GAIN,  r.deriv_gain);
        write_reg(pidc_pkg::REG_DRIVE_MAX,   r.drive_max);
        write_reg(pidc_pkg::REG_DRIVE_MIN,   r.drive_min);
        write_reg(pidc_pkg::REG_INTEG_LIMIT, {1'($urandom), r.integ_limit});
        write_reg(REG_UNUSED,                16'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Drop valid, drain every pending result, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one transaction and hold it until accepted
    task automatic push_item(input logic act, input logic signed [DW-1:0] sp,
                             input logic signed [DW-1:0] ms);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        setpoint <= sp;
        measured <= ms;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [15:0] corner_value();
        case ($urandom_range(4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // Small gains keep the loop out of saturation most of the time
    function automatic logic [pidc_pkg::GAIN_W-1:0] random_gain();
        case ($urandom_range(5))
            0, 1:    return pidc_pkg::GAIN_W'($urandom_range(512));
            2:       return pidc_pkg::GAIN_W'($urandom_range(4096));
            3:       return pidc_pkg::GAIN_W'($urandom);
            4:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic pidc_pkg::cfg_t random_regs();
        pidc_pkg::cfg_t r;
        int             pick;
        r.pid_form   = 1'($urandom_range(1));
        r.prop_gain  = random_gain();
        r.integ_gain = random_gain();
        r.deriv_gain = random_gain();
        pick = $urandom_range(9);
        if (pick < 7)
        begin
            r.drive_max = 16'($urandom_range(32767));
            r.drive_min = 16'(-int'($urandom_range(32768)));
        end
        else if (pick < 8)
        begin
            r.drive_max = 16'($urandom);
            r.drive_min = 16'($urandom);
        end
        else
        begin
            r.drive_max = corner_value();
            r.drive_min = corner_value();
        end
        case ($urandom_range(4))
            0, 1:    r.integ_limit = pidc_pkg::LIMIT_W'($urandom_range(2000));
            2:       r.integ_limit = pidc_pkg::LIMIT_W'($urandom);
            3:       r.integ_limit = '0;
            default: r.integ_limit = '1;
        endcase
        return r;
    endfunction

    // Tracking-style and full-range errors in equal share, some corner values, rare clears
    task automatic random_step();
        int                   pick;
        int                   base;
        logic signed [DW-1:0] sp;
        logic signed [DW-1:0] ms;
        if ($urandom_range(24) == 0)
        begin
            push_item(pidc_pkg::ACT_CLEAR, DW'($urandom), DW'($urandom));
        end
        else
        begin
            pick = $urandom_range(9);
            if (pick < 4)
            begin
                sp = DW'($urandom);
                ms = DW'($urandom);
            end
            else if (pick < 8)
            begin
                base = int'($urandom_range(4000)) - 2000;
                sp = DW'(base);
                ms = DW'(base + int'($urandom_range(200)) - 100);
            end
            else
            begin
                sp = corner_value();
                ms = corner_value();
            end
            push_item(pidc_pkg::ACT_STEP, sp, ms);
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        action    <= pidc_pkg::ACT_STEP;
        setpoint  <= '0;
        measured  <= '0;
        hold_req  <= 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 56;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: zero gains give zero drive
        push_item(pidc_pkg::ACT_STEP, 16'sd1000, -16'sd1000);
        wait_idle();

        // incremental form, unity-ish gains, full-scale errors both ways, clear mid-run
        load_regs('{pid_form: pidc_pkg::FORM_INCREMENTAL, prop_gain: 16'h0100,
                    integ_gain: 16'h0080, deriv_gain: 16'h0040,
                    drive_max: 16'sh7FFF, drive_min: 16'sh8000,
                    integ_limit: 15'd19660});
        push_item(pidc_pkg::ACT_STEP, 16'sh7FFF, 16'sh8000);
        push_item(pidc_pkg::ACT_STEP, 16'sh8000, 16'sh7FFF);
        push_item(pidc_pkg::ACT_STEP, 16'sd0, 16'sd0);
        push_item(pidc_pkg::ACT_CLEAR, 16'sd0, 16'sd0);
        push_item(pidc_pkg::ACT_STEP, 16'sd100, 16'sd40);
        push_item(pidc_pkg::ACT_STEP, -16'sd5, 16'sd3);
        wait_idle();

        // positional form, maximum gains, error sum pinned at zero
        load_regs('{pid_form: pidc_pkg::FORM_POSITIONAL, prop_gain: 16'hFFFF,
                    integ_gain: 16'hFFFF, deriv_gain: 16'hFFFF,
                    drive_max: 16'sh7FFF, drive_min: 16'sh8000,
                    integ_limit: 15'd0});
        push_item(pidc_pkg::ACT_STEP, 16'sh7FFF, 16'sh8000);
        push_item(pidc_pkg::ACT_STEP, 16'sh8000, 16'sh7FFF);
        push_item(pidc_pkg::ACT_STEP, 16'sd1, 16'sd0);
        push_item(pidc_pkg::ACT_CLEAR, 16'sh7FFF, 16'sh8000);
        wait_idle();

        // positional form, crossed clamps, error sum saturating at the widest limit
        load_regs('{pid_form: pidc_pkg::FORM_POSITIONAL, prop_gain: 16'h0010,
                    integ_gain: 16'h0100, deriv_gain: 16'h0020,
                    drive_max: -16'sd100, drive_min: 16'sd100,
                    integ_limit: 15'h7FFF});
        push_item(pidc_pkg::ACT_STEP, 16'sh7FFF, 16'sh8000);
        push_item(pidc_pkg::ACT_STEP, 16'sh7FFF, 16'sh8000);
        push_item(pidc_pkg::ACT_STEP, 16'sh8000, 16'sh7FFF);
        push_item(pidc_pkg::ACT_STEP, 16'sd0, 16'sd0);
        wait_idle();

        // incremental form, both clamps at the bottom of the range
        load_regs('{pid_form: pidc_pkg::FORM_INCREMENTAL, prop_gain: 16'h0001,
                    integ_gain: 16'h0001, deriv_gain: 16'h0001,
                    drive_max: 16'sh8000, drive_min: 16'sh8000,
                    integ_limit: 15'd0});
        push_item(pidc_pkg::ACT_STEP, 16'sd5, 16'sd0);
        push_item(pidc_pkg::ACT_STEP, -16'sd1, 16'sd0);
        push_item(pidc_pkg::ACT_CLEAR, 16'sd0, 16'sd0);
        wait_idle();

        // random phases: receiver-heavy idling, then sender-heavy, then none
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph < RAND_PHASES / 3)
            begin
                send_idle_pct = 38;
                recv_idle_pct = 56;
            end
            else if (ph < 2 * RAND_PHASES / 3)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 38;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            load_regs(random_regs());
            // long output stall while the sender keeps offering
            if (ph == 1)
                hold_req <= 1'b1;
            repeat (PHASE_ITEMS) random_step();
            wait_idle();
        end

        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* pid_controller_incremental_positional_core.f */
rtl/pidc_pkg.sv
rtl/pidc_step.sv
rtl/pid_controller_incremental_positional_core.sv
rtl/pidc_checker.sv
tb/pidc_drive_checker.sv
tb/tb.sv
